// ===== src/ebmlhp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EBML element header parser package
// Shared types and constants for the element header parser.
// ----------------------------------------------------------------------------
package ebmlhp_pkg;

    localparam int MAX_VINT_OCTETS = 8;
    localparam logic [7:0] MARKER_TOP = 8'h80;
    localparam int ID_W = 64;
    localparam int SIZE_W = 56;
    localparam int BYTE_W = 8;
    localparam int LEFT_W = 3;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_ID      = 2'd0,
        PH_SIZE    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_HALT    = 2'd3
    } t_phase;

    typedef struct packed {
        logic              bad;
        logic [LEFT_W-1:0] extra;
        logic [BYTE_W-1:0] stripped;
    } t_lead;

    typedef struct packed {
        logic              has;
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic [BYTE_W-1:0] pbyte;
        logic              last;
    } t_result;

endpackage

// ===== src/ebmlhp_vint_lead.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vint leading byte decoder
// Finds the octet count of a vint from its first byte, strips the length
// marker and flags a malformed first byte.
// ----------------------------------------------------------------------------
module ebmlhp_vint_lead
    import ebmlhp_pkg::*;
(
    input  logic [BYTE_W-1:0] i_byte,
    output t_lead             o_lead
);

    logic [3:0]        octets;
    logic [BYTE_W-1:0] mark;

    always_comb begin
        octets = 4'd9;
        for (int i = 0; i < BYTE_W; i++) begin
            if (i_byte[i]) begin
                octets = 4'(BYTE_W - i);
            end
        end
        mark = MARKER_TOP >> (octets - 4'd1);
        o_lead.bad      = (i_byte == '0) || (octets > 4'(MAX_VINT_OCTETS));
        o_lead.extra    = LEFT_W'(octets - 4'd1);
        o_lead.stripped = i_byte ^ mark;
    end

endmodule

// ===== src/ebmlhp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Element header parser core
// Holds the parse state and works out the result and next state for one word.
// ----------------------------------------------------------------------------
module ebmlhp_core
    import ebmlhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_result
);

    t_phase            r_phase, n_phase;
    logic [LEFT_W-1:0] r_left, n_left;
    logic [ID_W-1:0]   r_id, n_id;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W-1:0] r_pay_left, n_pay_left;
    t_lead             lead;

    ebmlhp_vint_lead u_lead (
        .i_byte (i_byte),
        .o_lead (lead)
    );

    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_id       = r_id;
        n_size     = r_size;
        n_pay_left = r_pay_left;
        unique case (r_phase)
            PH_ID: begin
                if (r_left == '0) begin
                    if (lead.bad) begin
                        n_phase = PH_HALT;
                    end else begin
                        n_id   = ID_W'(i_byte);
                        n_left = lead.extra;
                        if (lead.extra == '0) begin
                            n_phase = PH_SIZE;
                        end
                    end
                end else begin
                    n_id   = {r_id[ID_W-BYTE_W-1:0], i_byte};
                    n_left = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_phase = PH_SIZE;
                    end
                end
            end
            PH_SIZE: begin
                if (r_left == '0) begin
                    if (lead.bad) begin
                        n_phase = PH_HALT;
                    end else begin
                        n_size = SIZE_W'(lead.stripped);
                        n_left = lead.extra;
                    end
                end else begin
                    n_size = {r_size[SIZE_W-BYTE_W-1:0], i_byte};
                    n_left = r_left - 1'b1;
                end
                if (!lead.bad || r_left != '0) begin
                    if (n_left == '0) begin
                        n_pay_left = n_size;
                        n_phase    = (n_size != '0) ? PH_PAYLOAD : PH_ID;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_pay_left = r_pay_left - 1'b1;
                if (r_pay_left == SIZE_W'(1)) begin
                    n_phase = PH_ID;
                end
            end
            PH_HALT: begin
                n_left = '0;
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end

    always_comb begin
        o_result = '0;
        unique case (r_phase)
            PH_ID: begin
                if (r_left == '0 && lead.bad) begin
                    o_result.has  = 1'b1;
                    o_result.kind = KIND_ERROR;
                end
            end
            PH_SIZE: begin
                if (r_left == '0 && lead.bad) begin
                    o_result.has  = 1'b1;
                    o_result.kind = KIND_ERROR;
                end else if (n_left == '0) begin
                    o_result.has  = 1'b1;
                    o_result.kind = KIND_HEADER;
                    o_result.id   = r_id;
                    o_result.size = n_size;
                end
            end
            PH_PAYLOAD: begin
                o_result.has   = 1'b1;
                o_result.kind  = KIND_PAYLOAD;
                o_result.pbyte = i_byte;
                o_result.last  = (r_pay_left == SIZE_W'(1));
            end
            PH_HALT: begin
                o_result.has = 1'b0;
            end
            default: begin
                o_result.has = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ID;
            r_left     <= '0;
            r_id       <= '0;
            r_size     <= '0;
            r_pay_left <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_left     <= n_left;
            r_id       <= n_id;
            r_size     <= n_size;
            r_pay_left <= n_pay_left;
        end
    end

endmodule

// ===== src/ebml_element_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EBML element header parser
// Parses a flat stream of EBML elements into header results and payload words.
// ----------------------------------------------------------------------------
// Each input word is one byte of the element stream; the block takes one word
// per clock while o_stall is low. A word is held in an input register, decoded
// by the parser core in a single pass, and any result lands in the output
// register when the core steps on the word. ID bytes and all but the
// last size byte give no result; the last size byte gives one header word with
// the ID (marker kept) and size (marker removed); each payload byte gives one
// payload word, with the last flag on the final one. A first vint byte of zero
// gives an error word, after which the block takes words but gives no result
// until reset.
module ebml_element_header_parser
    import ebmlhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_result_kind,
    output logic [ID_W-1:0]   o_element_id,
    output logic [SIZE_W-1:0] o_element_size,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_last_payload
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           res;
    logic              step;
    logic              in_accept;

    ebmlhp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (res)
    );

    assign step      = r_in_valid && (!res.has || !r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !step;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res.has) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.has) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out.kind;
    assign o_element_id   = r_out.id;
    assign o_element_size = r_out.size;
    assign o_payload_byte = r_out.pbyte;
    assign o_last_payload = r_out.last;

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_result_kind == KIND_ERROR |=> !o_valid)
        else $error("result word after error");

    a_last_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_payload |-> o_result_kind == KIND_PAYLOAD)
        else $error("last flag on a non-payload word");

    a_non_header_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_HEADER |-> o_element_id == '0 && o_element_size == '0)
        else $error("header fields set on a non-header word");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output is free");

endmodule
